FILE: design/fnl_pkg.sv
// Shared types and constants for the three-nearest fingerprint locator.
// No dependencies; every design file imports this package.
package fnl_pkg;

  // Default geometry, handed to the top level as parameter defaults.
  localparam int GRID_COLS_DEF = 8;
  localparam int GRID_ROWS_DEF = 8;
  localparam int NUM_APS_DEF   = 4;

  // Number of signal-strength fields carried on the input ports.
  localparam int PORT_APS = 4;

  localparam int RSS_W   = 12;
  localparam int SQ_W    = 24;  // square of a 13-bit difference fits in 24 bits
  localparam int DIST_W  = 27;
  localparam logic [DIST_W-1:0] DIST_CAP = 27'd85332992;  // 333332 in Q.8

  localparam int COORD_W = 6;
  localparam int SUM_W   = 8;   // three coordinates of up to 63
  localparam int SCALE_W = 4;
  localparam logic [SCALE_W-1:0] SCALE_RST = 4'd2;
  localparam int PROD_W  = SUM_W + SCALE_W;
  localparam int NUM_W   = PROD_W + 8;

  // Division by three as a multiply by a rounded-up reciprocal.
  localparam int RECIP_SHIFT = NUM_W + 2;
  localparam int RECIP_W     = RECIP_SHIFT - 1;
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3);
  localparam int MULT_W      = NUM_W + RECIP_W;
  localparam int QUOT_W      = MULT_W - RECIP_SHIFT;

  localparam int POS_W = 15;
  localparam logic [POS_W-1:0] POS_MAX = 15'd32767;

  // Tag that travels with a cell through the distance pipeline.
  typedef struct packed {
    logic               valid;
    logic               usable;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } tag_t;

endpackage

FILE: design/fnl_lane.sv
// One access-point lane: difference of reference and query strength, squared.
// Depends on fnl_pkg for field widths.
module fnl_lane
  import fnl_pkg::*;
(
  input  logic                    clk,
  input  logic signed [RSS_W-1:0] ref_rss,
  input  logic signed [RSS_W-1:0] qry_rss,
  output logic [SQ_W-1:0]         sq
);

  logic signed [RSS_W:0]     diff;
  logic signed [2*RSS_W+1:0] prod;

  always_comb begin
    diff = {ref_rss[RSS_W-1], ref_rss} - {qry_rss[RSS_W-1], qry_rss};
    prod = diff * diff;
  end

  always_ff @(posedge clk) begin
    sq <= prod[SQ_W-1:0];
  end

endmodule

FILE: design/fnl_merge.sv
// Merging stage: sums the lane squares into a distance and keeps the three
// nearest cells in order. Depends on fnl_pkg.
module fnl_merge
  import fnl_pkg::*;
#(
  parameter int NUM_APS = NUM_APS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  tag_t                            tag_in,
  input  logic [NUM_APS-1:0][SQ_W-1:0]    sq,
  output logic                            busy,
  output logic [SUM_W-1:0]                sum_x,
  output logic [SUM_W-1:0]                sum_y
);

  logic [DIST_W-1:0]  dist_sum;
  logic [DIST_W-1:0]  dist_r;
  tag_t               tag_r;
  logic [DIST_W-1:0]  best_dist [3];
  logic [COORD_W-1:0] best_x [3];
  logic [COORD_W-1:0] best_y [3];
  logic               take;

  always_comb begin
    dist_sum = '0;
    for (int a = 0; a < NUM_APS; a++) begin
      dist_sum = dist_sum + DIST_W'(sq[a]);
    end
  end

  always_ff @(posedge clk) begin
    dist_r       <= dist_sum;
    tag_r.usable <= tag_in.usable;
    tag_r.x      <= tag_in.x;
    tag_r.y      <= tag_in.y;
    if (rst) begin
      tag_r.valid <= 1'b0;
    end else begin
      tag_r.valid <= tag_in.valid;
    end
  end

  assign take = tag_r.valid && tag_r.usable;

  // Strict less-than: an equal distance found later never displaces an earlier cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        best_dist[i] <= DIST_CAP;
        best_x[i]    <= '0;
        best_y[i]    <= '0;
      end
    end else if (start) begin
      for (int i = 0; i < 3; i++) begin
        best_dist[i] <= DIST_CAP;
      end
    end else if (take) begin
      if (dist_r < best_dist[0]) begin
        best_dist[2] <= best_dist[1];
        best_x[2]    <= best_x[1];
        best_y[2]    <= best_y[1];
        best_dist[1] <= best_dist[0];
        best_x[1]    <= best_x[0];
        best_y[1]    <= best_y[0];
        best_dist[0] <= dist_r;
        best_x[0]    <= tag_r.x;
        best_y[0]    <= tag_r.y;
      end else if (dist_r < best_dist[1]) begin
        best_dist[2] <= best_dist[1];
        best_x[2]    <= best_x[1];
        best_y[2]    <= best_y[1];
        best_dist[1] <= dist_r;
        best_x[1]    <= tag_r.x;
        best_y[1]    <= tag_r.y;
      end else if (dist_r < best_dist[2]) begin
        best_dist[2] <= dist_r;
        best_x[2]    <= tag_r.x;
        best_y[2]    <= tag_r.y;
      end
    end
  end

  assign busy  = tag_r.valid;
  assign sum_x = SUM_W'(best_x[0]) + SUM_W'(best_x[1]) + SUM_W'(best_x[2]);
  assign sum_y = SUM_W'(best_y[0]) + SUM_W'(best_y[1]) + SUM_W'(best_y[2]);

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    best_dist[0] <= best_dist[1] && best_dist[1] <= best_dist[2])
    else $error("nearest-cell distances out of order");

  a_capped: assert property (@(posedge clk) disable iff (rst)
    best_dist[2] <= DIST_CAP)
    else $error("kept distance above the cap");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    start |=> best_dist[0] == DIST_CAP && best_dist[2] == DIST_CAP)
    else $error("distances not reset at the start of a query");

  a_skip_unusable: assert property (@(posedge clk) disable iff (rst)
    tag_r.valid && !tag_r.usable && !start |=>
      $stable(best_dist[0]) && $stable(best_x[0]) && $stable(best_y[0]) &&
      $stable(best_dist[2]) && $stable(best_x[2]) && $stable(best_y[2]))
    else $error("unusable cell changed the nearest set");

endmodule

FILE: design/fnl_centroid.sv
// Centroid unit: multiplies the coordinate sums by the grid scale, divides by
// three through a reciprocal multiply and saturates. Depends on fnl_pkg.
module fnl_centroid
  import fnl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SCALE_W-1:0] scale,
  input  logic [SUM_W-1:0]   sum_x,
  input  logic [SUM_W-1:0]   sum_y,
  output logic               done,
  output logic [POS_W-1:0]   pos_x,
  output logic [POS_W-1:0]   pos_y
);

  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  logic              prod_valid;
  logic [MULT_W-1:0] mult_x;
  logic [MULT_W-1:0] mult_y;
  logic [QUOT_W-1:0] quot_x;
  logic [QUOT_W-1:0] quot_y;

  always_ff @(posedge clk) begin
    prod_x <= PROD_W'(scale) * PROD_W'(sum_x);
    prod_y <= PROD_W'(scale) * PROD_W'(sum_y);
  end

  // The reciprocal error stays below one sixth, so the truncated quotient is exact.
  always_comb begin
    mult_x = MULT_W'({prod_x, 8'd0}) * MULT_W'(RECIP_3);
    mult_y = MULT_W'({prod_y, 8'd0}) * MULT_W'(RECIP_3);
    quot_x = mult_x[MULT_W-1:RECIP_SHIFT];
    quot_y = mult_y[MULT_W-1:RECIP_SHIFT];
  end

  always_ff @(posedge clk) begin
    pos_x <= (quot_x > QUOT_W'(POS_MAX)) ? POS_MAX : quot_x[POS_W-1:0];
    pos_y <= (quot_y > QUOT_W'(POS_MAX)) ? POS_MAX : quot_y[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= start;
      done       <= prod_valid;
    end
  end

endmodule

FILE: design/fingerprint_three_nearest_locator_top.sv
// Load request: written into the reference memory at acceptance.
// Query request: the result follows a scan of all GRID_COLS*GRID_ROWS cells, the pipeline
// drain and the centroid step; the next request is taken once the result is in the output
// register. The scan reads the reference memory's single read port, one cell per cycle.
// Reset (synchronous) clears control, grid_scale to 2 and the kept cells to zero;
// the reference memory is not cleared and must be loaded before it is searched.
module fingerprint_three_nearest_locator_top
  import fnl_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int NUM_APS   = NUM_APS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SCALE_W-1:0]      cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    mode,
  input  logic [2:0]              cell_x,
  input  logic [2:0]              cell_y,
  input  logic                    cell_usable,
  input  logic signed [RSS_W-1:0] rss_ap0,
  input  logic signed [RSS_W-1:0] rss_ap1,
  input  logic signed [RSS_W-1:0] rss_ap2,
  input  logic signed [RSS_W-1:0] rss_ap3,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [POS_W-1:0]        pos_x_q8,
  output logic [POS_W-1:0]        pos_y_q8
);

  localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
  localparam int CW        = $clog2(NUM_CELLS);
  localparam int XW        = $clog2(GRID_COLS);
  localparam int YW        = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int MEM_W     = NUM_APS * RSS_W + 1;

  typedef enum logic [2:0] {IDLE, SCAN, DRAIN, FINISH, HOLD} state_t;

  state_t                   state;
  logic [SCALE_W-1:0]       grid_scale;
  logic [MEM_W-1:0]         mem [NUM_CELLS];
  logic [MEM_W-1:0]         entry;
  logic [MEM_W-1:0]         wr_data;
  logic [CW-1:0]            wr_addr;
  logic [CW-1:0]            rd_addr;
  logic [XW-1:0]            x_cnt;
  logic [YW-1:0]            y_cnt;
  logic                     load_we;
  logic                     query_go;
  logic                     out_free;
  logic                     out_load;
  logic                     pipe_empty;
  logic                     cen_start;
  logic signed [3:0][RSS_W-1:0] rss_port;
  logic signed [RSS_W-1:0]  rss_in [NUM_APS];
  logic signed [RSS_W-1:0]  qry [NUM_APS];
  logic [NUM_APS-1:0][SQ_W-1:0] sq;
  tag_t                     tag1;
  tag_t                     tag2;
  logic                     merge_busy;
  logic [SUM_W-1:0]         sum_x;
  logic [SUM_W-1:0]         sum_y;
  logic                     cen_done;
  logic [POS_W-1:0]         cen_x;
  logic [POS_W-1:0]         cen_y;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && (((state == FINISH) && cen_done) || (state == HOLD));

  // Access points beyond the four carried on the ports read as zero.
  assign rss_port = {rss_ap3, rss_ap2, rss_ap1, rss_ap0};

  always_comb begin
    wr_data    = '0;
    wr_data[0] = cell_usable;
    for (int a = 0; a < NUM_APS; a++) begin
      rss_in[a] = (a < PORT_APS) ? rss_port[2'(a)] : '0;
      wr_data[a*RSS_W+1 +: RSS_W] = rss_in[a];
    end
  end

  assign wr_addr  = CW'(int'(cell_x) * GRID_ROWS + int'(cell_y));
  assign load_we  = in_valid && !in_stall && !mode &&
                    (int'(cell_x) < GRID_COLS) && (int'(cell_y) < GRID_ROWS);
  assign query_go = in_valid && !in_stall && mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_scale <= SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      grid_scale <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[wr_addr] <= wr_data;
    end
    entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (query_go) begin
      for (int a = 0; a < NUM_APS; a++) begin
        qry[a] <= rss_in[a];
      end
    end
  end

  // Cell tags follow the memory read and the lane registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
      tag2.valid <= 1'b0;
    end else begin
      tag1.valid <= (state == SCAN);
      tag2.valid <= tag1.valid;
    end
    tag1.usable <= 1'b0;
    tag1.x      <= COORD_W'(x_cnt);
    tag1.y      <= COORD_W'(y_cnt);
    tag2.usable <= entry[0];
    tag2.x      <= tag1.x;
    tag2.y      <= tag1.y;
  end

  for (genvar a = 0; a < NUM_APS; a++) begin : g_lane
    fnl_lane u_lane (
      .clk     (clk),
      .ref_rss (entry[a*RSS_W+1 +: RSS_W]),
      .qry_rss (qry[a]),
      .sq      (sq[a])
    );
  end

  fnl_merge #(
    .NUM_APS (NUM_APS)
  ) u_merge (
    .clk    (clk),
    .rst    (rst),
    .start  (query_go),
    .tag_in (tag2),
    .sq     (sq),
    .busy   (merge_busy),
    .sum_x  (sum_x),
    .sum_y  (sum_y)
  );

  assign pipe_empty = !tag1.valid && !tag2.valid && !merge_busy;
  assign cen_start  = (state == DRAIN) && pipe_empty;

  fnl_centroid u_centroid (
    .clk   (clk),
    .rst   (rst),
    .start (cen_start),
    .scale (grid_scale),
    .sum_x (sum_x),
    .sum_y (sum_y),
    .done  (cen_done),
    .pos_x (cen_x),
    .pos_y (cen_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rd_addr   <= '0;
      x_cnt     <= '0;
      y_cnt     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        pos_x_q8  <= cen_x;
        pos_y_q8  <= cen_y;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          rd_addr <= '0;
          x_cnt   <= '0;
          y_cnt   <= '0;
          if (query_go) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          rd_addr <= rd_addr + 1'b1;
          if (y_cnt == YW'(GRID_ROWS - 1)) begin
            y_cnt <= '0;
            x_cnt <= x_cnt + 1'b1;
          end else begin
            y_cnt <= y_cnt + 1'b1;
          end
          if (rd_addr == CW'(NUM_CELLS - 1)) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (pipe_empty) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (cen_done) begin
            if (out_free) begin
              state <= IDLE;
            end else begin
              state <= HOLD;
            end
          end
        end
        HOLD: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
